### src/kvlt_pkg.sv
`timescale 1ns / 1ps

package kvlt_pkg;

  // longest string that parses; later characters set the error state
  localparam int MAX_LEN = 4096;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int POS_W   = $clog2(MAX_LEN + 1);

  // result field widths
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  // characters the parser cares about
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h27;

  typedef enum logic [8:0] {
    ST_BEFORE_KEY  = 9'b000000001,
    ST_IN_KEY      = 9'b000000010,
    ST_AFTER_KEY   = 9'b000000100,
    ST_AFTER_EQ    = 9'b000001000,
    ST_OPEN_QUOTE  = 9'b000010000,
    ST_PLAIN       = 9'b000100000,
    ST_QUOTED      = 9'b001000000,
    ST_AFTER_VAL   = 9'b010000000,
    ST_ERR         = 9'b100000000
  } parse_st_t;

  typedef struct packed {
    parse_st_t        st;
    logic [POS_W-1:0] position;
    logic [IDX_W-1:0] key_begin;
    logic [IDX_W-1:0] key_finish;
    logic [IDX_W-1:0] value_begin;
    logic [POS_W-1:0] value_finish;
    logic             in_spaces;
  } parser_t;

  localparam parser_t PARSER_RESET = '{
    st:           ST_BEFORE_KEY,
    position:     '0,
    key_begin:    '0,
    key_finish:   '0,
    value_begin:  '0,
    value_finish: '0,
    in_spaces:    1'b0
  };

  typedef struct packed {
    logic               pair;
    logic [START_W-1:0] key_start;
    logic [LEN_W-1:0]   key_length;
    logic [START_W-1:0] value_start;
    logic [LEN_W-1:0]   value_length;
    logic               done;
    logic               err;
  } result_t;

endpackage

### src/key_value_list_tokenizer.sv
`timescale 1ns / 1ps

// Tokenizer for a comma-separated list of KEY=VALUE or KEY='VALUE' pairs,
// fed one Latin-1 character per word with last marking the final character.
// The parser state advances as each word is accepted, and any result
// lands in a single output register, so a new character is taken every
// clock while out_ready is high or while that output register is empty.
// A word yields a result only when a pair completes or when it is the
// last character; the result gives start and length of key and value,
// and on the last character done_res plus parse_error. Positions count
// from zero at the first character of each string; characters at position
// 4096 and beyond put the parser in its error state. After the last
// character the parser is back in its reset state, ready for the next
// string.
module key_value_list_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pair_valid,
  output logic [11:0] key_start,
  output logic [12:0] key_length,
  output logic [11:0] value_start,
  output logic [12:0] value_length,
  output logic        done_res,
  output logic        parse_error
);
  import kvlt_pkg::*;

  parser_t parser;
  parser_t parser_next;
  result_t step_res;
  result_t result;
  logic    accept;

  // output register frees up when empty or being taken this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // next-state logic for one character
  kvlt_step u_step (
    .cur  (parser),
    .ch   (ch),
    .last (last),
    .nxt  (parser_next),
    .res  (step_res)
  );

  // parser state advances on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      parser <= PARSER_RESET;
    end else if (accept) begin
      parser <= parser_next;
    end
  end

  // result register; words that produce nothing leave it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && (step_res.pair || step_res.done);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= step_res;
    end
  end

  assign pair_valid   = result.pair;
  assign key_start    = result.key_start;
  assign key_length   = result.key_length;
  assign value_start  = result.value_start;
  assign value_length = result.value_length;
  assign done_res     = result.done;
  assign parse_error  = result.err;

  // the last character always produces a done result
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (out_valid && done_res))
    else $error("last character did not produce a done result");

  // a result only exists for a pair or the end of a string
  a_no_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_valid || done_res))
    else $error("result without pair or done");

  // error status only rides on a done result
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && parse_error) |-> done_res)
    else $error("parse_error without done_res");

  // fields stay zero when no pair is reported
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pair_valid) |-> (key_length == '0 && value_length == '0 &&
                                    key_start == '0 && value_start == '0))
    else $error("pair fields set without a pair");

endmodule

### src/kvlt_step.sv
`timescale 1ns / 1ps

module kvlt_step (
  input  kvlt_pkg::parser_t cur,
  input  logic [7:0]        ch,
  input  logic              last,
  output kvlt_pkg::parser_t nxt,
  output kvlt_pkg::result_t res
);
  import kvlt_pkg::*;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_SPACE);
  endfunction

  parser_t          nx;
  logic [IDX_W-1:0] pos;
  logic             emit;
  logic [POS_W-1:0] emit_b;
  logic [POS_W-1:0] emit_e;
  logic [POS_W-1:0] vlen;
  logic [IDX_W-1:0] klen;
  logic             blank;

  assign pos   = cur.position[IDX_W-1:0];
  assign blank = is_blank(ch);

  always_comb begin
    nx     = cur;
    emit   = 1'b0;
    emit_b = '0;
    emit_e = '0;

    if (cur.position < POS_W'(MAX_LEN)) begin
      nx.position = cur.position + POS_W'(1);
      unique case (cur.st)
        ST_BEFORE_KEY: begin
          if (blank || ch == CH_COMMA) begin
            nx.st = cur.st;
          end else if (ch == CH_EQ || ch == CH_QUOTE) begin
            nx.st = ST_ERR;
          end else begin
            nx.key_begin = pos;
            nx.st        = ST_IN_KEY;
          end
        end
        ST_IN_KEY: begin
          if (blank) begin
            nx.key_finish = pos;
            nx.st         = ST_AFTER_KEY;
          end else if (ch == CH_EQ) begin
            nx.key_finish = pos;
            nx.st         = ST_AFTER_EQ;
          end
        end
        ST_AFTER_KEY: begin
          if (ch == CH_EQ) begin
            nx.st = ST_AFTER_EQ;
          end else if (!blank) begin
            nx.st = ST_ERR;
          end
        end
        ST_AFTER_EQ: begin
          if (blank) begin
            nx.st = cur.st;
          end else if (ch == CH_QUOTE) begin
            nx.st = ST_OPEN_QUOTE;
          end else if (ch == CH_COMMA) begin
            emit  = 1'b1;
            nx.st = ST_BEFORE_KEY;
          end else begin
            nx.value_begin = pos;
            nx.in_spaces   = 1'b0;
            nx.st          = ST_PLAIN;
          end
        end
        ST_OPEN_QUOTE: begin
          if (ch == CH_QUOTE) begin
            emit  = 1'b1;
            nx.st = ST_AFTER_VAL;
          end else begin
            nx.value_begin = pos;
            nx.st          = ST_QUOTED;
          end
        end
        ST_PLAIN: begin
          if (blank) begin
            if (!cur.in_spaces) begin
              nx.in_spaces    = 1'b1;
              nx.value_finish = cur.position;
            end
          end else if (ch == CH_COMMA) begin
            if (!cur.in_spaces) begin
              nx.value_finish = cur.position;
            end
            emit         = 1'b1;
            emit_b       = POS_W'(cur.value_begin);
            emit_e       = cur.in_spaces ? cur.value_finish : cur.position;
            nx.in_spaces = 1'b0;
            nx.st        = ST_BEFORE_KEY;
          end else begin
            nx.in_spaces = 1'b0;
          end
        end
        ST_QUOTED: begin
          if (ch == CH_QUOTE) begin
            nx.value_finish = cur.position;
            emit            = 1'b1;
            emit_b          = POS_W'(cur.value_begin);
            emit_e          = cur.position;
            nx.st           = ST_AFTER_VAL;
          end
        end
        ST_AFTER_VAL: begin
          if (ch == CH_COMMA) begin
            nx.st = ST_BEFORE_KEY;
          end else if (!blank) begin
            nx.st = ST_ERR;
          end
        end
        default: begin
          nx.st = ST_ERR;
        end
      endcase
    end else begin
      nx.st = ST_ERR;
    end

    // end of string flushes a pending plain or empty value
    if (last) begin
      if (nx.st == ST_PLAIN) begin
        if (!nx.in_spaces) begin
          nx.value_finish = nx.position;
        end
        emit   = 1'b1;
        emit_b = POS_W'(nx.value_begin);
        emit_e = nx.value_finish;
      end else if (nx.st == ST_AFTER_EQ) begin
        emit   = 1'b1;
        emit_b = '0;
        emit_e = '0;
      end
    end
  end

  assign klen = (nx.key_finish > nx.key_begin) ? (nx.key_finish - nx.key_begin) : '0;
  assign vlen = (emit_e > emit_b) ? (emit_e - emit_b) : '0;

  always_comb begin
    res.pair         = emit;
    res.key_start    = emit ? START_W'(nx.key_begin) : '0;
    res.key_length   = emit ? LEN_W'(klen) : '0;
    res.value_start  = (emit && emit_e > emit_b) ? START_W'(emit_b) : '0;
    res.value_length = emit ? LEN_W'(vlen) : '0;
    res.done         = last;
    res.err          = last && (nx.st == ST_ERR);
  end

  assign nxt = last ? PARSER_RESET : nx;

endmodule
